FILE: hw/rtl/cql_frame_deframer_handshake_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Shared property forms used by the block's concurrent checks.
//------------------------------------------------------------------------------
`ifndef CQL_FRAME_DEFRAMER_HANDSHAKE_DEFINES_SVH
`define CQL_FRAME_DEFRAMER_HANDSHAKE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CQL_FD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define CQL_FD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cql_fd_pkg.sv
//------------------------------------------------------------------------------
// Frame deframer package
// Word types, event and link codes, and protocol constants.
//------------------------------------------------------------------------------
`default_nettype none

package cql_fd_pkg;

	// Protocol opcodes
	localparam logic [7:0] OP_ERROR        = 8'h00;
	localparam logic [7:0] OP_READY        = 8'h02;
	localparam logic [7:0] OP_AUTHENTICATE = 8'h03;
	localparam logic [7:0] OP_SUPPORTED    = 8'h06;
	localparam logic [7:0] OP_RESULT       = 8'h08;
	localparam logic [7:0] OP_AUTH_SUCCESS = 8'h10;

	// Result kinds
	localparam logic [31:0] KIND_VOID = 32'h0000_0001;
	localparam logic [31:0] KIND_ROWS = 32'h0000_0002;

	// Register reset and protocol versions
	localparam logic [31:0] MAX_FRAME_RESET = 32'(16 * 1024 * 1024);
	localparam logic [2:0]  VER_4 = 3'd4;
	localparam logic [2:0]  VER_5 = 3'd5;

	// Header is nine bytes; count value HDR_BYTES marks the body phase
	localparam logic [3:0] HDR_BYTES = 4'd9;
	localparam logic [3:0] HDR_LAST  = 4'd8;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_QUERY   = 2'd1,
		ACT_CONNECT = 2'd2,
		ACT_NOP     = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		LINK_IDLE      = 2'd0,
		LINK_HANDSHAKE = 2'd1,
		LINK_READY     = 2'd2,
		LINK_FAILED    = 2'd3
	} link_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_STARTUP   = 4'd1,
		EV_AUTH      = 4'd2,
		EV_READY     = 4'd3,
		EV_ERROR     = 4'd4,
		EV_VOID      = 4'd5,
		EV_ROWS      = 4'd6,
		EV_QFAIL     = 4'd7,
		EV_TOO_LONG  = 4'd8,
		EV_IGNORED   = 4'd9
	} event_t;

	// Classified input word
	typedef struct packed {
		act_t       kind;
		logic [7:0] data;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        body_last;
		event_t      frame_event;
		logic [7:0]  frame_opcode;
		logic [15:0] frame_stream;
		logic [31:0] frame_length;
		link_t       link_state;
		logic [2:0]  protocol_version;
	} res_t;

	// Back-end handshake with the command queue and the result queue
	typedef struct packed {
		logic cmd_valid;
		logic res_full;
	} back_in_t;

	typedef struct packed {
		logic cmd_pop;
		logic res_push;
	} back_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cql_frame_deframer_handshake.sv
// Path: a pushed word is stored in the command queue, processed by the back
//   end and its result is stored in the result queue, visible as empty low.
// Throughput: one word per cycle while full is low; the back end retires one
//   command per cycle, stalling only when the result queue is full.
// Reset: arst_n clears queues, deframer and link state; the frame size limit
//   returns to 16 MiB and the requested version to 5.
//------------------------------------------------------------------------------
// Frame deframer and handshake tracker
// Queue-style top level joining front end, back end and result queue.
//------------------------------------------------------------------------------
`default_nettype none

`include "cql_frame_deframer_handshake_defines.svh"

module cql_frame_deframer_handshake #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input queue side
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  rx_byte,
	// Result queue side
	output logic             empty,
	input  wire logic        pop,
	output logic             body_valid,
	output logic [7:0]       body_byte,
	output logic             body_last,
	output logic [3:0]       frame_event,
	output logic [7:0]       frame_opcode,
	output logic [15:0]      frame_stream,
	output logic [31:0]      frame_length,
	output logic [1:0]       link_state,
	output logic [2:0]       protocol_version,
	// Configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] max_frame_bytes
);

	localparam int RES_W = $bits(cql_fd_pkg::res_t);

	cql_fd_pkg::cmd_t      cmd;
	cql_fd_pkg::res_t      res_in, res_out;
	cql_fd_pkg::back_in_t  back_in;
	cql_fd_pkg::back_out_t back_out;
	logic                  cmd_valid;
	logic                  res_full;
	logic [RES_W-1:0]      res_bits;

	assign cfg_ready = 1'b1;

	cql_fd_front #(
		.DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.action    (action),
		.rx_byte   (rx_byte),
		.full      (full),
		.cmd_pop   (back_out.cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	assign back_in.cmd_valid = cmd_valid;
	assign back_in.res_full  = res_full;

	cql_fd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_max (max_frame_bytes),
		.ctl_in  (back_in),
		.cmd     (cmd),
		.ctl_out (back_out),
		.res     (res_in)
	);

	cql_fd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_out.res_push),
		.wr_data (RES_W'(res_in)),
		.rd_en   (pop),
		.rd_data (res_bits),
		.full    (res_full),
		.empty   (empty)
	);

	// Unpack the oldest result word
	assign res_out          = cql_fd_pkg::res_t'(res_bits);
	assign body_valid       = res_out.body_valid;
	assign body_byte        = res_out.body_byte;
	assign body_last        = res_out.body_last;
	assign frame_event      = res_out.frame_event;
	assign frame_opcode     = res_out.frame_opcode;
	assign frame_stream     = res_out.frame_stream;
	assign frame_length     = res_out.frame_length;
	assign link_state       = res_out.link_state;
	assign protocol_version = res_out.protocol_version;

	// Checks
	`CQL_FD_ASSERT_IMPLY(a_push_has_room, back_out.res_push, !res_full, "result pushed into full queue")
	`CQL_FD_ASSERT_IMPLY(a_last_has_event, back_out.res_push && res_in.body_last, res_in.frame_event != cql_fd_pkg::EV_NONE, "frame end without event")
	`CQL_FD_ASSERT_IMPLY(a_too_long_fails, back_out.res_push && res_in.frame_event == cql_fd_pkg::EV_TOO_LONG, res_in.link_state == cql_fd_pkg::LINK_FAILED, "oversize frame left link up")
	`CQL_FD_ASSERT_NEXT(a_push_fills, back_out.res_push && !pop, !empty, "pushed result not visible")

endmodule

`default_nettype wire

FILE: hw/rtl/cql_fd_fifo.sv
//------------------------------------------------------------------------------
// Word queue
// Small register queue with first-word fall-through read.
//------------------------------------------------------------------------------
`default_nettype none

module cql_fd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cql_fd_front.sv
//------------------------------------------------------------------------------
// Deframer front end
// Accepts input words, classifies the action and queues them for the back end.
//------------------------------------------------------------------------------
`default_nettype none

module cql_fd_front #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [1:0]       action,
	input  wire logic [7:0]       rx_byte,
	output logic                  full,
	input  wire logic             cmd_pop,
	output logic                  cmd_valid,
	output cql_fd_pkg::cmd_t      cmd
);

	localparam int CMD_W = $bits(cql_fd_pkg::cmd_t);

	cql_fd_pkg::cmd_t   cls;
	logic [CMD_W-1:0]   rd_bits;
	logic               q_empty;

	// Classify the action; only received bytes carry data
	always_comb begin
		cls.data = 8'h00;
		case (action)
			cql_fd_pkg::ACT_BYTE: begin
				cls.kind = cql_fd_pkg::ACT_BYTE;
				cls.data = rx_byte;
			end
			cql_fd_pkg::ACT_QUERY:   cls.kind = cql_fd_pkg::ACT_QUERY;
			cql_fd_pkg::ACT_CONNECT: cls.kind = cql_fd_pkg::ACT_CONNECT;
			default:                 cls.kind = cql_fd_pkg::ACT_NOP;
		endcase
	end

	cql_fd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (CMD_W'(cls)),
		.rd_en   (cmd_pop),
		.rd_data (rd_bits),
		.full    (full),
		.empty   (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = cql_fd_pkg::cmd_t'(rd_bits);

endmodule

`default_nettype wire

FILE: hw/rtl/cql_fd_back.sv
//------------------------------------------------------------------------------
// Deframer back end
// Header collection, body pass-through and connection state machine.
//------------------------------------------------------------------------------
`default_nettype none

module cql_fd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [31:0]           cfg_max,
	input  wire cql_fd_pkg::back_in_t  ctl_in,
	input  wire cql_fd_pkg::cmd_t      cmd,
	output cql_fd_pkg::back_out_t      ctl_out,
	output cql_fd_pkg::res_t           res
);

	logic [31:0]         max_q;
	logic [3:0]          cnt_q, cnt_n;
	logic [7:0]          opc_q, opc_n;
	logic [15:0]         strm_q, strm_n;
	logic [31:0]         len_q, len_n;
	logic [31:0]         rem_q, rem_n;
	logic [31:0]         kind_q, kind_n;
	cql_fd_pkg::link_t   link_q, link_n;
	logic                qact_q, qact_n;
	logic [2:0]          ver_q, ver_n;
	logic                halt_q, halt_n;
	logic                bv, bl, fin, step;
	logic [7:0]          bb;
	logic [31:0]         pos, rem_dec;
	cql_fd_pkg::event_t  ev;

	// Process one word whenever one waits and the result queue has room
	assign step             = ctl_in.cmd_valid && !ctl_in.res_full;
	assign ctl_out.cmd_pop  = step;
	assign ctl_out.res_push = step;

	assign pos     = len_q - rem_q;
	assign rem_dec = (rem_q != '0) ? rem_q - 32'd1 : rem_q;

	// Next state and result for the word at the head of the queue
	always_comb begin
		cnt_n  = cnt_q;
		opc_n  = opc_q;
		strm_n = strm_q;
		len_n  = len_q;
		rem_n  = rem_q;
		kind_n = kind_q;
		link_n = link_q;
		qact_n = qact_q;
		ver_n  = ver_q;
		halt_n = halt_q;
		bv     = 1'b0;
		bb     = 8'h00;
		bl     = 1'b0;
		fin    = 1'b0;
		ev     = cql_fd_pkg::EV_NONE;

		case (cmd.kind)
			cql_fd_pkg::ACT_CONNECT: begin
				link_n = cql_fd_pkg::LINK_HANDSHAKE;
				cnt_n  = '0;
				rem_n  = '0;
				kind_n = '0;
				halt_n = 1'b0;
				qact_n = 1'b0;
				if (ver_q != cql_fd_pkg::VER_4) begin
					ver_n = cql_fd_pkg::VER_5;
				end
			end
			cql_fd_pkg::ACT_QUERY: begin
				if (link_q == cql_fd_pkg::LINK_READY) begin
					qact_n = 1'b1;
				end
			end
			cql_fd_pkg::ACT_BYTE: begin
				if (!halt_q) begin
					if (cnt_q < cql_fd_pkg::HDR_BYTES) begin
						// Collect big-endian header fields
						case (cnt_q)
							4'd2:             strm_n = {cmd.data, strm_q[7:0]};
							4'd3:             strm_n = {strm_q[15:8], cmd.data};
							4'd4:             opc_n  = cmd.data;
							4'd5:             len_n  = {24'h0, cmd.data};
							4'd6, 4'd7, 4'd8: len_n  = {len_q[23:0], cmd.data};
							default:          ;
						endcase
						cnt_n = cnt_q + 4'd1;
						if (cnt_q == cql_fd_pkg::HDR_LAST) begin
							kind_n = '0;
							if (len_n > max_q) begin
								link_n = cql_fd_pkg::LINK_FAILED;
								halt_n = 1'b1;
								cnt_n  = '0;
								ev     = cql_fd_pkg::EV_TOO_LONG;
							end else if (len_n == '0) begin
								cnt_n = '0;
								fin   = 1'b1;
							end else begin
								rem_n = len_n;
							end
						end
					end else begin
						// Pass the body byte, capture the result kind
						if (pos < 32'd4) begin
							kind_n = {kind_q[23:0], cmd.data};
						end
						bv    = 1'b1;
						bb    = cmd.data;
						rem_n = rem_dec;
						if (rem_dec == '0) begin
							bl    = 1'b1;
							cnt_n = '0;
							fin   = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		// Finish the frame: drive the connection state machine
		if (fin) begin
			if (opc_n == cql_fd_pkg::OP_ERROR) begin
				if (ver_q == cql_fd_pkg::VER_5) begin
					ver_n = cql_fd_pkg::VER_4;
				end
				link_n = cql_fd_pkg::LINK_FAILED;
				qact_n = 1'b0;
				ev     = cql_fd_pkg::EV_ERROR;
			end else if (link_q != cql_fd_pkg::LINK_READY) begin
				if (opc_n == cql_fd_pkg::OP_SUPPORTED && link_q != cql_fd_pkg::LINK_IDLE) begin
					ev = cql_fd_pkg::EV_STARTUP;
				end else if (opc_n == cql_fd_pkg::OP_AUTHENTICATE) begin
					ev = cql_fd_pkg::EV_AUTH;
				end else if (opc_n == cql_fd_pkg::OP_AUTH_SUCCESS ||
						opc_n == cql_fd_pkg::OP_READY) begin
					link_n = cql_fd_pkg::LINK_READY;
					ev     = cql_fd_pkg::EV_READY;
				end else begin
					ev = cql_fd_pkg::EV_IGNORED;
				end
			end else if (!qact_q) begin
				ev = cql_fd_pkg::EV_IGNORED;
			end else begin
				qact_n = 1'b0;
				if (opc_n != cql_fd_pkg::OP_RESULT || len_n < 32'd4) begin
					ev = cql_fd_pkg::EV_QFAIL;
				end else if (kind_n == cql_fd_pkg::KIND_VOID) begin
					ev = cql_fd_pkg::EV_VOID;
				end else if (kind_n == cql_fd_pkg::KIND_ROWS) begin
					ev = cql_fd_pkg::EV_ROWS;
				end else begin
					ev = cql_fd_pkg::EV_QFAIL;
				end
			end
		end

		res.body_valid       = bv;
		res.body_byte        = bb;
		res.body_last        = bl;
		res.frame_event      = ev;
		res.frame_opcode     = opc_n;
		res.frame_stream     = strm_n;
		res.frame_length     = len_n;
		res.link_state       = link_n;
		res.protocol_version = ver_n;
	end

	// Hold the frame size limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= cql_fd_pkg::MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_max;
		end
	end

	// Advance deframer and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			opc_q  <= '0;
			strm_q <= '0;
			len_q  <= '0;
			rem_q  <= '0;
			kind_q <= '0;
			link_q <= cql_fd_pkg::LINK_IDLE;
			qact_q <= 1'b0;
			ver_q  <= cql_fd_pkg::VER_5;
			halt_q <= 1'b0;
		end else if (step) begin
			cnt_q  <= cnt_n;
			opc_q  <= opc_n;
			strm_q <= strm_n;
			len_q  <= len_n;
			rem_q  <= rem_n;
			kind_q <= kind_n;
			link_q <= link_n;
			qact_q <= qact_n;
			ver_q  <= ver_n;
			halt_q <= halt_n;
		end
	end

endmodule

`default_nettype wire
